[src/uartsp_pkg.sv]
// Shared types and constants for the serial port with parity.
package uartsp_pkg;

  localparam int unsigned BREAK_TICKS = 24;

  // Counter values that mark frame positions.
  localparam logic [3:0] TX_CNT_FRAME  = 4'd10;
  localparam logic [3:0] TX_CNT_PARITY = 4'd2;
  localparam logic [3:0] TX_CNT_STOP   = 4'd1;
  localparam logic [3:0] TX_CNT_IDLE   = 4'd0;

  localparam logic [4:0] RX_CNT_FRAME  = 5'd10;
  localparam logic [4:0] RX_CNT_PARITY = 5'd2;
  localparam logic [4:0] RX_CNT_STOP   = 5'd1;
  localparam logic [4:0] RX_CNT_IDLE   = 5'd0;
  localparam logic [4:0] RX_CNT_BREAK  = 5'd11;
  localparam logic [4:0] RX_CNT_MAX    = 5'd31;
  localparam logic [4:0] RX_BRK_LIMIT  = 5'(BREAK_TICKS);

  // Error bit positions inside the receive error word.
  localparam int unsigned RXE_BRK  = 0;
  localparam int unsigned RXE_FRAM = 1;
  localparam int unsigned RXE_OVR  = 2;
  localparam int unsigned RXE_PAR  = 3;

  // Control byte bit positions.
  localparam int unsigned CTL_TXINTEN = 7;
  localparam int unsigned CTL_PAREN   = 4;
  localparam int unsigned CTL_RSTERR  = 3;
  localparam int unsigned CTL_TXBRK   = 1;
  localparam int unsigned CTL_PARBIT  = 0;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_WR_CTRL   = 3'd1,
    ACT_WR_DATA   = 3'd2,
    ACT_RD_STATUS = 3'd3,
    ACT_RD_DATA   = 3'd4
  } action_t;

  // Decoded operation for one accepted transaction.
  typedef struct packed {
    logic       tick;
    logic       wr_ctrl;
    logic       wr_data;
    logic       rd_data;
    logic       line;
    logic [7:0] wdata;
  } unit_cmd_t;

  typedef struct packed {
    logic       hold_full;
    logic [7:0] hold;
    logic [3:0] errors;
    logic       parity;
  } rx_status_t;

  typedef struct packed {
    logic hold_full;
    logic idle;
    logic level_next;
    logic irq_next;
  } tx_status_t;

endpackage

[src/uart_serial_port_with_parity_unit.sv]
// Top level of the serial port with parity: decode, receiver, transmitter, result stage.
//
// Every transaction (bit tick, control write, data write, status read or data
// read) can be accepted every cycle while in_stall is low. The state update
// and the result are formed combinationally from the accepted fields; the
// result is registered in the result register, and a second skid register
// absorbs one result while the output side stalls, so in_stall rises only
// once two results are waiting. line_out and irq give the levels after the
// transaction; read_data is zero for anything other than a read.
module uart_serial_port_with_parity_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] write_data,
  input  logic       line_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       line_out,
  output logic       irq
);

  typedef struct packed {
    logic [7:0] rdata;
    logic       line;
    logic       irq;
  } result_t;

  uartsp_pkg::unit_cmd_t  cmd;
  uartsp_pkg::rx_status_t rx_status;
  uartsp_pkg::tx_status_t tx_status;
  logic                   accept;
  logic                   out_take;
  result_t                res_now;
  result_t                res_out;
  result_t                res_skid;
  logic                   skid_valid;
  logic [7:0]             rdata_now;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    cmd       = '0;
    cmd.line  = line_in;
    cmd.wdata = write_data;
    rdata_now = '0;
    unique case (action)
      uartsp_pkg::ACT_TICK:    cmd.tick    = 1'b1;
      uartsp_pkg::ACT_WR_CTRL: cmd.wr_ctrl = 1'b1;
      uartsp_pkg::ACT_WR_DATA: cmd.wr_data = 1'b1;
      uartsp_pkg::ACT_RD_STATUS:
        rdata_now = {!tx_status.hold_full, rx_status.hold_full, tx_status.idle,
                     rx_status.errors, rx_status.parity};
      uartsp_pkg::ACT_RD_DATA: begin
        cmd.rd_data = 1'b1;
        if (rx_status.hold_full) rdata_now = rx_status.hold;
      end
      default: ;
    endcase
  end

  uartsp_rx u_rx (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .status (rx_status)
  );

  uartsp_tx u_tx (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .status (tx_status)
  );

  assign res_now.rdata = rdata_now;
  assign res_now.line  = tx_status.level_next;
  assign res_now.irq   = tx_status.irq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          // Output is held; park the new result.
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || out_take) res_out <= res_now;
      else res_skid <= res_now;
    end else if (out_take && skid_valid) begin
      res_out <= res_skid;
    end
  end

  assign read_data = res_out.rdata;
  assign line_out  = res_out.line;
  assign irq       = res_out.irq;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    accept && out_valid && out_stall |=> skid_valid && out_valid)
    else $error("result accepted under stall was not parked");

endmodule

[src/uartsp_rx.sv]
// Receiver: frame deserializer, holding register, error and break detection.
module uartsp_rx (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  uartsp_pkg::unit_cmd_t  cmd,
  output uartsp_pkg::rx_status_t status
);

  logic [7:0] rx_hold, rx_hold_next;
  logic       rx_hold_full, rx_hold_full_next;
  logic [4:0] rx_bit_count, rx_bit_count_next;
  logic [8:0] rx_shift, rx_shift_next;
  logic       rx_parity_acc, rx_parity_acc_next;
  logic [3:0] rx_errors, rx_errors_next;

  always_comb begin
    rx_hold_next       = rx_hold;
    rx_hold_full_next  = rx_hold_full;
    rx_bit_count_next  = rx_bit_count;
    rx_shift_next      = rx_shift;
    rx_parity_acc_next = rx_parity_acc;
    rx_errors_next     = rx_errors;
    if (accept && cmd.tick) begin
      case (rx_bit_count) inside
        [5'd3:uartsp_pkg::RX_CNT_FRAME]: begin
          rx_shift_next      = {1'b0, rx_shift[8] | cmd.line, rx_shift[7:1]};
          rx_parity_acc_next = rx_parity_acc ^ cmd.line;
          rx_bit_count_next  = rx_bit_count - 5'd1;
        end
        uartsp_pkg::RX_CNT_PARITY: begin
          if (rx_parity_acc != cmd.line) rx_errors_next[uartsp_pkg::RXE_PAR] = 1'b1;
          rx_bit_count_next = uartsp_pkg::RX_CNT_STOP;
        end
        uartsp_pkg::RX_CNT_STOP: begin
          if (cmd.line) begin
            if (rx_hold_full) rx_errors_next[uartsp_pkg::RXE_OVR] = 1'b1;
            rx_hold_next      = rx_shift[7:0];
            rx_hold_full_next = 1'b1;
            rx_bit_count_next = uartsp_pkg::RX_CNT_IDLE;
          end else begin
            rx_errors_next[uartsp_pkg::RXE_FRAM] = 1'b1;
            rx_bit_count_next = uartsp_pkg::RX_CNT_BREAK;
          end
        end
        uartsp_pkg::RX_CNT_IDLE: begin
          if (!cmd.line) begin
            rx_bit_count_next  = uartsp_pkg::RX_CNT_FRAME;
            rx_parity_acc_next = 1'b0;
            rx_shift_next      = '0;
          end
        end
        default: begin
          // Post-framing-error low run; saturate the count.
          if (!cmd.line) begin
            if (rx_bit_count >= uartsp_pkg::RX_BRK_LIMIT)
              rx_errors_next[uartsp_pkg::RXE_BRK] = 1'b1;
            if (rx_bit_count < uartsp_pkg::RX_CNT_MAX)
              rx_bit_count_next = rx_bit_count + 5'd1;
          end else begin
            rx_bit_count_next = uartsp_pkg::RX_CNT_IDLE;
          end
        end
      endcase
    end
    if (accept && cmd.wr_ctrl && cmd.wdata[uartsp_pkg::CTL_RSTERR]) rx_errors_next = '0;
    if (accept && cmd.rd_data) rx_hold_full_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_hold       <= '0;
      rx_hold_full  <= 1'b0;
      rx_bit_count  <= uartsp_pkg::RX_CNT_IDLE;
      rx_shift      <= '0;
      rx_parity_acc <= 1'b0;
      rx_errors     <= '0;
    end else begin
      rx_hold       <= rx_hold_next;
      rx_hold_full  <= rx_hold_full_next;
      rx_bit_count  <= rx_bit_count_next;
      rx_shift      <= rx_shift_next;
      rx_parity_acc <= rx_parity_acc_next;
      rx_errors     <= rx_errors_next;
    end
  end

  assign status.hold_full = rx_hold_full;
  assign status.hold      = rx_hold;
  assign status.errors    = rx_errors;
  assign status.parity    = rx_parity_acc;

  a_rx_start: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.tick && !cmd.line && rx_bit_count == uartsp_pkg::RX_CNT_IDLE
    |=> rx_bit_count == uartsp_pkg::RX_CNT_FRAME)
    else $error("receiver did not start a frame on a low line");

  a_rx_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_bit_count < uartsp_pkg::RX_CNT_BREAK |=> rx_bit_count <= uartsp_pkg::RX_CNT_BREAK)
    else $error("receiver count left the frame range");

endmodule

[src/uartsp_tx.sv]
// Transmitter: holding register, frame serializer, control flags and interrupt.
module uartsp_tx (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  uartsp_pkg::unit_cmd_t  cmd,
  output uartsp_pkg::tx_status_t status
);

  logic [7:0] tx_hold, tx_hold_next;
  logic       tx_hold_full, tx_hold_full_next;
  logic [3:0] tx_bit_count, tx_bit_count_next;
  logic [7:0] tx_shift, tx_shift_next;
  logic       tx_parity_acc, tx_parity_acc_next;
  logic       tx_level, tx_level_next;
  logic       tx_irq, tx_irq_next;
  logic       paren, paren_next;
  logic       parbit, parbit_next;
  logic       txbrk, txbrk_next;
  logic       txinten, txinten_next;

  always_comb begin
    tx_hold_next       = tx_hold;
    tx_hold_full_next  = tx_hold_full;
    tx_bit_count_next  = tx_bit_count;
    tx_shift_next      = tx_shift;
    tx_parity_acc_next = tx_parity_acc;
    tx_level_next      = tx_level;
    tx_irq_next        = tx_irq;
    paren_next         = paren;
    parbit_next        = parbit;
    txbrk_next         = txbrk;
    txinten_next       = txinten;
    if (accept && cmd.tick) begin
      case (tx_bit_count)
        uartsp_pkg::TX_CNT_PARITY: begin
          tx_level_next     = paren ? tx_parity_acc : parbit;
          tx_bit_count_next = uartsp_pkg::TX_CNT_STOP;
        end
        uartsp_pkg::TX_CNT_STOP: begin
          tx_level_next     = 1'b1;
          tx_bit_count_next = uartsp_pkg::TX_CNT_IDLE;
          tx_irq_next       = txinten;
        end
        uartsp_pkg::TX_CNT_IDLE: begin
          if (txbrk) begin
            tx_level_next = 1'b0;
          end else if (tx_hold_full) begin
            // Start bit; load the shifter.
            tx_level_next      = 1'b0;
            tx_shift_next      = tx_hold;
            tx_hold_full_next  = 1'b0;
            tx_bit_count_next  = uartsp_pkg::TX_CNT_FRAME;
            tx_parity_acc_next = 1'b0;
          end else begin
            tx_level_next = 1'b1;
          end
        end
        default: begin
          tx_level_next      = tx_shift[0];
          tx_parity_acc_next = tx_parity_acc ^ tx_shift[0];
          tx_shift_next      = {1'b0, tx_shift[7:1]};
          tx_bit_count_next  = tx_bit_count - 4'd1;
        end
      endcase
    end
    if (accept && cmd.wr_ctrl) begin
      if (!txinten) tx_irq_next = 1'b0;
      txinten_next = cmd.wdata[uartsp_pkg::CTL_TXINTEN];
      txbrk_next   = cmd.wdata[uartsp_pkg::CTL_TXBRK];
      parbit_next  = cmd.wdata[uartsp_pkg::CTL_PARBIT];
      paren_next   = cmd.wdata[uartsp_pkg::CTL_PAREN];
    end
    if (accept && cmd.wr_data) begin
      tx_hold_next      = cmd.wdata;
      tx_hold_full_next = 1'b1;
      if (!txinten) tx_irq_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_hold       <= '0;
      tx_hold_full  <= 1'b0;
      tx_bit_count  <= uartsp_pkg::TX_CNT_IDLE;
      tx_shift      <= '0;
      tx_parity_acc <= 1'b0;
      tx_level      <= 1'b1;
      tx_irq        <= 1'b0;
      paren         <= 1'b0;
      parbit        <= 1'b0;
      txbrk         <= 1'b0;
      txinten       <= 1'b0;
    end else begin
      tx_hold       <= tx_hold_next;
      tx_hold_full  <= tx_hold_full_next;
      tx_bit_count  <= tx_bit_count_next;
      tx_shift      <= tx_shift_next;
      tx_parity_acc <= tx_parity_acc_next;
      tx_level      <= tx_level_next;
      tx_irq        <= tx_irq_next;
      paren         <= paren_next;
      parbit        <= parbit_next;
      txbrk         <= txbrk_next;
      txinten       <= txinten_next;
    end
  end

  assign status.hold_full  = tx_hold_full;
  assign status.idle       = (tx_bit_count == uartsp_pkg::TX_CNT_IDLE);
  assign status.level_next = tx_level_next;
  assign status.irq_next   = tx_irq_next;

  a_tx_stop_high: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.tick && tx_bit_count == uartsp_pkg::TX_CNT_STOP |=> tx_level)
    else $error("stop bit not driven high");

  a_tx_start_low: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.tick && tx_bit_count == uartsp_pkg::TX_CNT_IDLE && tx_hold_full && !txbrk
    |=> !tx_level && !tx_hold_full && tx_bit_count == uartsp_pkg::TX_CNT_FRAME)
    else $error("frame start did not load the shifter");

endmodule
